>>> hdl/srpm_pkg.sv
// shared types and constants for the sv39 region page mapper
// used by srpm_ctrl, srpm_dpath and the top level; no dependencies

package srpm_pkg;

    localparam int TABLE_FRAMES_DEF = 64;
    localparam int SLOT_W           = 9;
    localparam int SLOTS            = 512;
    localparam int PPN_W            = 44;
    localparam int VPN_W            = 27;
    localparam int CNT_W            = 21;
    localparam int PERM_W           = 10;
    localparam int PTE_W            = 64;
    localparam int IN_DATA_W        = 104;
    localparam int OUT_DATA_W       = 88;
    localparam int LFRAME_W         = 6;
    localparam int FIU_W            = 7;

    localparam logic [PPN_W-1:0] BASE_RESET = 44'd524288;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_OUT_OF_POOL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        LVL_ROOT = 2'd0,
        LVL_MID  = 2'd1,
        LVL_LEAF = 2'd2
    } t_lvl;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RD1,
        S_CK1,
        S_ZERO1,
        S_RD2,
        S_CK2,
        S_ZERO2,
        S_RD3,
        S_WR3,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    zero_step;
        logic    load;
        logic    rd;
        t_lvl    lvl;
        logic    chk;
        logic    leaf_wr;
        logic    fail;
        t_status fail_code;
        logic    emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ent_valid;
        logic out_of_pool;
        logic pool_full;
        logic zero_last;
        logic region_done;
    } t_stat;

    typedef struct packed {
        logic [FIU_W-1:0]    frames_in_use;
        logic [SLOT_W-1:0]   leaf_slot;
        logic [LFRAME_W-1:0] leaf_frame;
        logic [PTE_W-1:0]    last_leaf_entry;
        t_status             status;
    } t_result;

endpackage

>>> hdl/srpm_ctrl.sv
// walk sequencer for the region page mapper
// depends on srpm_pkg for state, command and status types

module srpm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    input  srpm_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output srpm_pkg::t_cmd  o_cmd
);

    srpm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srpm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            srpm_pkg::S_CLEAR: begin
                if (i_stat.zero_last) n_state = srpm_pkg::S_IDLE;
            end
            srpm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = srpm_pkg::S_START;
            end
            srpm_pkg::S_START: begin
                n_state = i_stat.region_done ? srpm_pkg::S_DONE : srpm_pkg::S_RD1;
            end
            srpm_pkg::S_RD1: n_state = srpm_pkg::S_CK1;
            srpm_pkg::S_CK1: begin
                if (i_stat.ent_valid) begin
                    n_state = i_stat.out_of_pool ? srpm_pkg::S_DONE : srpm_pkg::S_RD2;
                end else begin
                    n_state = i_stat.pool_full ? srpm_pkg::S_DONE : srpm_pkg::S_ZERO1;
                end
            end
            srpm_pkg::S_ZERO1: begin
                if (i_stat.zero_last) n_state = srpm_pkg::S_RD2;
            end
            srpm_pkg::S_RD2: n_state = srpm_pkg::S_CK2;
            srpm_pkg::S_CK2: begin
                if (i_stat.ent_valid) begin
                    n_state = i_stat.out_of_pool ? srpm_pkg::S_DONE : srpm_pkg::S_RD3;
                end else begin
                    n_state = i_stat.pool_full ? srpm_pkg::S_DONE : srpm_pkg::S_ZERO2;
                end
            end
            srpm_pkg::S_ZERO2: begin
                if (i_stat.zero_last) n_state = srpm_pkg::S_RD3;
            end
            srpm_pkg::S_RD3: n_state = srpm_pkg::S_WR3;
            srpm_pkg::S_WR3: n_state = srpm_pkg::S_START;
            srpm_pkg::S_DONE: begin
                if (i_out_free) n_state = srpm_pkg::S_IDLE;
            end
            default: n_state = srpm_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.lvl       = srpm_pkg::LVL_ROOT;
        o_cmd.fail_code = srpm_pkg::ST_OK;
        o_in_ready      = 1'b0;
        case (r_state)
            srpm_pkg::S_CLEAR, srpm_pkg::S_ZERO1, srpm_pkg::S_ZERO2: begin
                o_cmd.zero_step = 1'b1;
            end
            srpm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            srpm_pkg::S_RD1: begin
                o_cmd.rd  = 1'b1;
                o_cmd.lvl = srpm_pkg::LVL_ROOT;
            end
            srpm_pkg::S_RD2: begin
                o_cmd.rd  = 1'b1;
                o_cmd.lvl = srpm_pkg::LVL_MID;
            end
            srpm_pkg::S_RD3: begin
                o_cmd.rd  = 1'b1;
                o_cmd.lvl = srpm_pkg::LVL_LEAF;
            end
            srpm_pkg::S_CK1, srpm_pkg::S_CK2: begin
                o_cmd.chk = 1'b1;
                if (i_stat.ent_valid && i_stat.out_of_pool) begin
                    o_cmd.fail      = 1'b1;
                    o_cmd.fail_code = srpm_pkg::ST_OUT_OF_POOL;
                end else if (!i_stat.ent_valid && i_stat.pool_full) begin
                    o_cmd.fail      = 1'b1;
                    o_cmd.fail_code = srpm_pkg::ST_EXHAUSTED;
                end
            end
            srpm_pkg::S_WR3: o_cmd.leaf_wr = 1'b1;
            srpm_pkg::S_DONE: o_cmd.emit = i_out_free;
            default: o_cmd.zero_step = 1'b0;
        endcase
    end

endmodule

>>> hdl/srpm_dpath.sv
// table memory, frame allocator and walk registers of the region page mapper
// depends on srpm_pkg; driven by srpm_ctrl commands

module srpm_dpath #(
    parameter int TABLE_FRAMES = srpm_pkg::TABLE_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [srpm_pkg::PPN_W-1:0]   i_cfg_wdata,
    input  logic [srpm_pkg::VPN_W-1:0]   i_va_page,
    input  logic [srpm_pkg::PPN_W-1:0]   i_pa_page,
    input  logic [srpm_pkg::CNT_W-1:0]   i_page_count,
    input  logic [srpm_pkg::PERM_W-1:0]  i_perm,
    input  srpm_pkg::t_cmd               i_cmd,
    output srpm_pkg::t_stat              o_stat,
    output srpm_pkg::t_result            o_result
);

    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int NW    = FW + 1;
    localparam int AW    = FW + srpm_pkg::SLOT_W;
    localparam int DEPTH = TABLE_FRAMES * srpm_pkg::SLOTS;

    logic [srpm_pkg::PTE_W-1:0]  r_mem [DEPTH];
    logic [srpm_pkg::PTE_W-1:0]  r_rd;

    logic [srpm_pkg::PPN_W-1:0]  r_base;
    logic [NW-1:0]               r_nff;
    logic [FW-1:0]               r_zframe;
    logic [srpm_pkg::SLOT_W-1:0] r_zcnt;

    logic [srpm_pkg::VPN_W-1:0]  r_va;
    logic [srpm_pkg::PPN_W-1:0]  r_pa;
    logic [srpm_pkg::CNT_W-1:0]  r_left;
    logic [srpm_pkg::PERM_W-1:0] r_perm;
    logic [FW-1:0]               r_frame;
    logic [AW-1:0]               r_addr;

    srpm_pkg::t_status           r_status;
    logic [srpm_pkg::PTE_W-1:0]  r_leaf;
    logic [FW-1:0]               r_lframe;
    logic [srpm_pkg::SLOT_W-1:0] r_lslot;

    logic [AW-1:0]               w_rd_addr;
    logic [AW-1:0]               w_addr;
    logic                        w_we;
    logic [srpm_pkg::PTE_W-1:0]  w_wdata;
    logic [srpm_pkg::PPN_W-1:0]  w_idx;
    logic [srpm_pkg::PPN_W-1:0]  w_new_ppn;
    logic                        w_valid;
    logic                        w_oop;
    logic                        w_full;
    logic                        w_alloc;
    logic [31:0]                 w_lframe32;
    logic [31:0]                 w_nff32;

    // entry checks on the word just read
    assign w_valid   = r_rd[0];
    assign w_idx     = r_rd[53:10] - r_base;
    assign w_oop     = (w_idx >= srpm_pkg::PPN_W'(TABLE_FRAMES));
    assign w_full    = (r_nff == NW'(TABLE_FRAMES));
    assign w_alloc   = i_cmd.chk && !w_valid && !w_full;
    assign w_new_ppn = r_base + srpm_pkg::PPN_W'(r_nff);

    always_comb begin
        case (i_cmd.lvl)
            srpm_pkg::LVL_ROOT: w_rd_addr = {{FW{1'b0}}, r_va[26:18]};
            srpm_pkg::LVL_MID:  w_rd_addr = {r_frame, r_va[17:9]};
            srpm_pkg::LVL_LEAF: w_rd_addr = {r_frame, r_va[8:0]};
            default:            w_rd_addr = {r_frame, r_va[8:0]};
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = '0;
        w_addr  = r_addr;
        if (i_cmd.zero_step) begin
            w_we   = 1'b1;
            w_addr = {r_zframe, r_zcnt};
        end else if (i_cmd.rd) begin
            w_addr = w_rd_addr;
        end else if (w_alloc) begin
            w_we    = 1'b1;
            w_wdata = {r_rd[63:54], w_new_ppn, 9'd0, 1'b1};
        end else if (i_cmd.leaf_wr) begin
            w_we    = 1'b1;
            w_wdata = {r_rd[63:54], r_pa, r_perm | srpm_pkg::PERM_W'(1)};
        end
    end

    // single port table memory, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= srpm_pkg::BASE_RESET;
            r_nff    <= NW'(1);
            r_zframe <= '0;
            r_zcnt   <= '0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_wdata;
            if (i_cmd.zero_step) r_zcnt <= r_zcnt + 1'b1;
            if (w_alloc) begin
                r_nff    <= r_nff + 1'b1;
                r_zframe <= r_nff[FW-1:0];
                r_zcnt   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_va     <= i_va_page;
            r_pa     <= i_pa_page;
            r_left   <= i_page_count;
            r_perm   <= i_perm;
            r_status <= srpm_pkg::ST_OK;
            r_leaf   <= '0;
            r_lframe <= '0;
            r_lslot  <= '0;
        end
        if (i_cmd.rd) r_addr <= w_rd_addr;
        if (i_cmd.chk && w_valid && !w_oop) r_frame <= w_idx[FW-1:0];
        if (w_alloc) r_frame <= r_nff[FW-1:0];
        if (i_cmd.fail) begin
            r_status <= i_cmd.fail_code;
            r_left   <= '0;
        end
        if (i_cmd.leaf_wr) begin
            r_leaf   <= w_wdata;
            r_lframe <= r_frame;
            r_lslot  <= r_va[8:0];
            r_va     <= r_va + 1'b1;
            r_pa     <= r_pa + 1'b1;
            r_left   <= r_left - 1'b1;
        end
    end

    assign w_lframe32 = 32'(r_lframe);
    assign w_nff32    = 32'(r_nff);

    assign o_stat.ent_valid   = w_valid;
    assign o_stat.out_of_pool = w_oop;
    assign o_stat.pool_full   = w_full;
    assign o_stat.zero_last   = (r_zcnt == '1);
    assign o_stat.region_done = (r_left == '0);

    assign o_result.status          = r_status;
    assign o_result.last_leaf_entry = r_leaf;
    assign o_result.leaf_frame      = w_lframe32[srpm_pkg::LFRAME_W-1:0];
    assign o_result.leaf_slot       = r_lslot;
    assign o_result.frames_in_use   = w_nff32[srpm_pkg::FIU_W-1:0];

endmodule

>>> hdl/sv39_region_page_mapper_core.sv
// sv39 region page mapper, top level: controller, datapath and output register
// result valid once the walk ends, set by the single table memory port (read, check/write
// per level for each page) and the zero sweep of each frame allocated
// next item can be taken in the cycle after its result is loaded;
// a stopped walk ends early, and a result still held in the output register stalls the done step
// after reset a pass zeroes the root frame with s_axis_tready low
// depends on srpm_pkg, srpm_ctrl, srpm_dpath

module sv39_region_page_mapper_core #(
    parameter int TABLE_FRAMES = srpm_pkg::TABLE_FRAMES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // table_base_page register
    input  logic                              i_cfg_we,
    input  logic [srpm_pkg::PPN_W-1:0]        i_cfg_wdata,
    // region request
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // va_page[26:0], pa_page[70:27], page_count[91:71], perm[101:92], zero pad
    input  logic [srpm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mapping result
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[1:0], last_leaf_entry[65:2], leaf_frame[71:66], leaf_slot[80:72],
    // frames_in_use[87:81]
    output logic [srpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    srpm_pkg::t_cmd    w_cmd;
    srpm_pkg::t_stat   w_stat;
    srpm_pkg::t_result w_result;
    logic              w_out_free;

    logic                            r_ovalid;
    logic [srpm_pkg::OUT_DATA_W-1:0] r_odata;

    // the result slot can take a new item when empty or drained this cycle
    assign w_out_free = !r_ovalid || m_axis_tready;

    srpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    srpm_dpath #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_va_page    (s_axis_tdata[26:0]),
        .i_pa_page    (s_axis_tdata[70:27]),
        .i_page_count (s_axis_tdata[91:71]),
        .i_perm       (s_axis_tdata[101:92]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_result     (w_result)
    );

    // output register, loaded when the walk finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) r_odata <= w_result;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // a result is only loaded into a free slot
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_out_free)
        else $error("result loaded over an untaken item");

    // an accepted request keeps the input closed while it is walked
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input open right after accepting an item");

    // status codes stay within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("undefined status code on result");

    // walk commands never coincide with loading a new request
    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !(w_cmd.rd || w_cmd.chk || w_cmd.leaf_wr || w_cmd.zero_step))
        else $error("request load during a walk step");

endmodule
